// File: hw/rtl/lmpc_pkg.sv
// Shared types, codes and reset constants for the LED mode PWM controller.
// No dependencies; every other file refers to this package by scoped names.
package lmpc_pkg;

    localparam int DutyWidth   = 10;
    localparam int PeriodWidth = 16;
    localparam int StepWidth   = 8;
    localparam int TimeWidth   = 32;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 16;

    localparam logic [DutyWidth-1:0] DutyMax = 10'd1023;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_BUTTON  = 2'd1,
        OP_COMMAND = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // LED modes
    typedef enum logic [2:0] {
        MODE_DARK    = 3'd0,
        MODE_ON      = 3'd1,
        MODE_BLINK   = 3'd2,
        MODE_FLASH   = 3'd3,
        MODE_BREATHE = 3'd4
    } mode_t;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_SLOW_HALF   = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_STROBE_HALF = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_BREATHE_INT = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_BREATHE_STEP = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE    = 3'd4;

    // Configuration reset values
    localparam logic [PeriodWidth-1:0] SlowHalfReset   = 16'd500;
    localparam logic [PeriodWidth-1:0] StrobeHalfReset = 16'd50;
    localparam logic [PeriodWidth-1:0] BreatheIntReset = 16'd10;
    localparam logic [StepWidth-1:0]   BreatheStepReset = 8'd5;
    localparam logic [StepWidth-1:0]   DebounceReset   = 8'd30;

    // Configuration bundle handed to the core
    typedef struct packed {
        logic [PeriodWidth-1:0] slow_half_period;
        logic [PeriodWidth-1:0] strobe_half_period;
        logic [PeriodWidth-1:0] breathe_interval;
        logic [StepWidth-1:0]   breathe_step;
        logic [StepWidth-1:0]   debounce_length;
    } cfg_t;

    // One input beat
    typedef struct packed {
        op_t                  operation;
        logic                 button_cycle_level;
        logic                 button_off_level;
        logic [2:0]           command_mode;
        logic [DutyWidth-1:0] sample_level;
    } item_t;

    // One result beat
    typedef struct packed {
        logic [DutyWidth-1:0] duty;
        mode_t                mode;
    } result_t;

endpackage

// File: hw/rtl/lmpc_cfg.sv
// Configuration register bank of the LED mode PWM controller.
// Depends on lmpc_pkg for the register indexes, reset values and cfg_t.
module lmpc_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [lmpc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lmpc_pkg::CfgDataWidth-1:0]   cfg_data,
    output lmpc_pkg::cfg_t                      cfg
);

    lmpc_pkg::cfg_t cfg_reg;

    // Decode the index and write the addressed register; other indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_half_period   <= lmpc_pkg::SlowHalfReset;
            cfg_reg.strobe_half_period <= lmpc_pkg::StrobeHalfReset;
            cfg_reg.breathe_interval   <= lmpc_pkg::BreatheIntReset;
            cfg_reg.breathe_step       <= lmpc_pkg::BreatheStepReset;
            cfg_reg.debounce_length    <= lmpc_pkg::DebounceReset;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                lmpc_pkg::CFG_SLOW_HALF:    cfg_reg.slow_half_period   <= cfg_data;
                lmpc_pkg::CFG_STROBE_HALF:  cfg_reg.strobe_half_period <= cfg_data;
                lmpc_pkg::CFG_BREATHE_INT:  cfg_reg.breathe_interval   <= cfg_data;
                lmpc_pkg::CFG_BREATHE_STEP:
                    cfg_reg.breathe_step <= cfg_data[lmpc_pkg::StepWidth-1:0];
                lmpc_pkg::CFG_DEBOUNCE:
                    cfg_reg.debounce_length <= cfg_data[lmpc_pkg::StepWidth-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/lmpc_core.sv
// Mode state and single-pass update of the LED mode PWM controller.
// Depends on lmpc_pkg; one registered item is folded into the state per enable.
module lmpc_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  lmpc_pkg::item_t    item,
    input  lmpc_pkg::cfg_t     cfg,
    output lmpc_pkg::result_t  result_next
);

    localparam int TW = lmpc_pkg::TimeWidth;
    localparam int DW = lmpc_pkg::DutyWidth;
    localparam int SW = lmpc_pkg::StepWidth;

    lmpc_pkg::mode_t   mode_reg, mode_next, mode_btn;
    logic [SW-1:0]     debounce_reg, debounce_next, debounce_btn;
    logic [TW-1:0]     ms_reg, ms_next;
    logic [1:0]        pins_reg, pins_next;
    logic [TW-1:0]     slow_last_reg, slow_last_next;
    logic              slow_lit_reg, slow_lit_next;
    logic [TW-1:0]     strobe_last_reg, strobe_last_next;
    logic              strobe_lit_reg, strobe_lit_next;
    logic [DW-1:0]     breathe_level_reg, breathe_level_next;
    logic              breathe_falling_reg, breathe_falling_next;
    logic [TW-1:0]     breathe_last_reg, breathe_last_next;
    logic [DW-1:0]     duty_reg, duty_next;

    logic              cycle_press, off_press;
    logic [TW-1:0]     slow_elapsed, strobe_elapsed, breathe_elapsed;
    logic              slow_due, strobe_due, breathe_due;
    logic [DW-1:0]     step_ext, rise_limit;

    // Button edges: cycle button first, its reload then blocks the off button unless the debounce length is zero
    always_comb
    begin
        mode_btn     = mode_reg;
        debounce_btn = debounce_reg;
        cycle_press  = !item.button_cycle_level && pins_reg[0] && (debounce_reg == '0);
        if (cycle_press)
        begin
            debounce_btn = cfg.debounce_length;
            mode_btn     = (mode_reg == lmpc_pkg::MODE_BREATHE) ? lmpc_pkg::MODE_DARK
                         : lmpc_pkg::mode_t'(mode_reg + 3'd1);
        end
        off_press = !item.button_off_level && pins_reg[1] && (debounce_btn == '0);
        if (off_press)
        begin
            debounce_btn = cfg.debounce_length;
            mode_btn     = lmpc_pkg::MODE_DARK;
        end
    end

    // Apply the operation to time, debounce, pins and mode
    always_comb
    begin
        ms_next       = ms_reg;
        debounce_next = debounce_reg;
        pins_next     = pins_reg;
        mode_next     = mode_reg;
        unique case (item.operation)
            lmpc_pkg::OP_TICK:
            begin
                ms_next = ms_reg + TW'(1);
                if (debounce_reg != '0)
                    debounce_next = debounce_reg - SW'(1);
            end
            lmpc_pkg::OP_BUTTON:
            begin
                debounce_next = debounce_btn;
                mode_next     = mode_btn;
                pins_next     = {item.button_off_level, item.button_cycle_level};
            end
            lmpc_pkg::OP_COMMAND:
            begin
                if (item.command_mode <= lmpc_pkg::MODE_BREATHE)
                    mode_next = lmpc_pkg::mode_t'(item.command_mode);
            end
            default: ;
        endcase
    end

    // Elapsed-time checks against the updated millisecond count
    assign slow_elapsed    = ms_next - slow_last_reg;
    assign strobe_elapsed  = ms_next - strobe_last_reg;
    assign breathe_elapsed = ms_next - breathe_last_reg;
    assign slow_due    = slow_elapsed    >= TW'(cfg.slow_half_period);
    assign strobe_due  = strobe_elapsed  >= TW'(cfg.strobe_half_period);
    assign breathe_due = breathe_elapsed >= TW'(cfg.breathe_interval);
    assign step_ext    = DW'(cfg.breathe_step);
    assign rise_limit  = lmpc_pkg::DutyMax - step_ext;

    // Run the rule of the new mode
    always_comb
    begin
        slow_last_next       = slow_last_reg;
        slow_lit_next        = slow_lit_reg;
        strobe_last_next     = strobe_last_reg;
        strobe_lit_next      = strobe_lit_reg;
        breathe_level_next   = breathe_level_reg;
        breathe_falling_next = breathe_falling_reg;
        breathe_last_next    = breathe_last_reg;
        duty_next            = duty_reg;
        unique case (mode_next)
            lmpc_pkg::MODE_DARK: duty_next = '0;
            lmpc_pkg::MODE_ON:   duty_next = item.sample_level;
            lmpc_pkg::MODE_BLINK:
            begin
                if (slow_due)
                begin
                    slow_last_next = ms_next;
                    slow_lit_next  = !slow_lit_reg;
                    duty_next      = slow_lit_reg ? '0 : item.sample_level;
                end
            end
            lmpc_pkg::MODE_FLASH:
            begin
                if (strobe_due)
                begin
                    strobe_last_next = ms_next;
                    strobe_lit_next  = !strobe_lit_reg;
                    duty_next        = strobe_lit_reg ? '0 : item.sample_level;
                end
            end
            default:
            begin
                if (breathe_due)
                begin
                    breathe_last_next = ms_next;
                    if (!breathe_falling_reg)
                    begin
                        if (breathe_level_reg >= rise_limit)
                        begin
                            breathe_level_next   = lmpc_pkg::DutyMax;
                            breathe_falling_next = 1'b1;
                        end
                        else
                            breathe_level_next = breathe_level_reg + step_ext;
                    end
                    else
                    begin
                        if (breathe_level_reg <= step_ext)
                        begin
                            breathe_level_next   = '0;
                            breathe_falling_next = 1'b0;
                        end
                        else
                            breathe_level_next = breathe_level_reg - step_ext;
                    end
                    duty_next = breathe_level_next;
                end
            end
        endcase
    end

    // Commit the state for each item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= lmpc_pkg::MODE_DARK;
            debounce_reg        <= '0;
            ms_reg              <= '0;
            pins_reg            <= 2'b11;
            slow_last_reg       <= '0;
            slow_lit_reg        <= 1'b0;
            strobe_last_reg     <= '0;
            strobe_lit_reg      <= 1'b0;
            breathe_level_reg   <= '0;
            breathe_falling_reg <= 1'b0;
            breathe_last_reg    <= '0;
            duty_reg            <= '0;
        end
        else if (enable)
        begin
            mode_reg            <= mode_next;
            debounce_reg        <= debounce_next;
            ms_reg              <= ms_next;
            pins_reg            <= pins_next;
            slow_last_reg       <= slow_last_next;
            slow_lit_reg        <= slow_lit_next;
            strobe_last_reg     <= strobe_last_next;
            strobe_lit_reg      <= strobe_lit_next;
            breathe_level_reg   <= breathe_level_next;
            breathe_falling_reg <= breathe_falling_next;
            breathe_last_reg    <= breathe_last_next;
            duty_reg            <= duty_next;
        end
    end

    assign result_next.duty = duty_next;
    assign result_next.mode = mode_next;

endmodule

// File: hw/rtl/led_mode_pwm_controller.sv
// LED mode PWM controller, top level. Depends on lmpc_pkg, lmpc_cfg and lmpc_core.
// Each input beat (tick, button sample or mode command) is captured in an input
// register, folded into the mode state in one pass and leaves as one result beat
// (duty, mode) from a result register. One beat is taken every clock while results
// drain. A stalled result holds the result register, and the input register then
// holds one further beat before in_stall rises.
module led_mode_pwm_controller
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic                                button_cycle_level,
    input  logic                                button_off_level,
    input  logic [2:0]                          command_mode,
    input  logic [lmpc_pkg::DutyWidth-1:0]      sample_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lmpc_pkg::DutyWidth-1:0]      duty,
    output logic [2:0]                          mode,
    input  logic                                cfg_write_en,
    input  logic [lmpc_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lmpc_pkg::CfgDataWidth-1:0]   cfg_data
);

    lmpc_pkg::cfg_t      cfg;
    lmpc_pkg::item_t     item_reg;
    lmpc_pkg::result_t   result_next;
    lmpc_pkg::result_t   result_reg;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;

    // Configuration registers
    lmpc_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // Move a beat into the result register when it is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    // Input register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    // Input register: payload
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.operation          <= lmpc_pkg::op_t'(operation);
            item_reg.button_cycle_level <= button_cycle_level;
            item_reg.button_off_level   <= button_off_level;
            item_reg.command_mode       <= command_mode;
            item_reg.sample_level       <= sample_level;
        end
    end

    // State update for the registered beat
    lmpc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .enable      (in_valid_reg && advance),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    // Result register: valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    // Result register: payload
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign duty      = result_reg.duty;
    assign mode      = result_reg.mode;

    // Off mode always reports a dark LED
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (mode == lmpc_pkg::MODE_DARK)) |-> (duty == '0))
        else $error("off mode result with non-zero duty");

    // A held input beat is not lost while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |=> in_valid_reg)
        else $error("input beat dropped under output stall");

    // A registered beat reaches a free result register in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("registered beat did not reach the result register");

    // A stalled result keeps its mode
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg.mode)))
        else $error("stalled result changed");

endmodule
